// File: rtl/lscn_pkg.sv
// Package for the line sensor calibrate/normalize block.
// Holds the sensor count, mode codes, control states, level and threshold constants, config indices
// and the lane command struct; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package lscn_pkg;

	localparam int NUM_SENSORS = 6;
	localparam int LEVEL_BITS = 10;
	localparam logic [LEVEL_BITS-1:0] LEVEL_FULL = 10'd1000;
	localparam int THR_BITS = 10;
	localparam logic [THR_BITS-1:0] WHITE_THR_RESET = 10'd1;
	localparam logic [THR_BITS-1:0] FLIP_THR_RESET = 10'd992;
	localparam int CFG_IDX_BITS = 1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_WHITE_THR = 1'b0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_FLIP_THR = 1'b1;

	typedef enum logic [2:0] {
		MODE_NOT_CAL = 3'd0,
		MODE_START   = 3'd1,
		MODE_CALIB   = 3'd2,
		MODE_STOP    = 3'd3,
		MODE_READY   = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		CTL_IDLE,
		CTL_WORK,
		CTL_HOLD
	} ctl_state_t;

	// one-cycle command from the control to every lane
	typedef struct packed {
		logic clear;
		logic track;
		logic norm;
	} lane_cmd_t;

endpackage
`default_nettype wire

// File: rtl/lscn_divider.sv
// Restoring divider: one quotient bit per cycle, unsigned.
// No package dependency; all widths come from the parameters.
`timescale 1ns / 1ps
`default_nettype none
module lscn_divider #(
	parameter int NUM_BITS = 26,
	parameter int DEN_BITS = 16
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 start,
	input  wire [NUM_BITS-1:0]  numer,
	input  wire [DEN_BITS-1:0]  denom,
	output logic                busy,
	output logic [NUM_BITS-1:0] quot
);
	localparam int CNT_BITS = $clog2(NUM_BITS + 1);

	logic [NUM_BITS-1:0] num_q;
	logic [DEN_BITS:0]   rem_q;
	logic [DEN_BITS-1:0] den_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic [DEN_BITS:0]   trial;
	logic [DEN_BITS:0]   diff;

	assign trial = {rem_q[DEN_BITS-1:0], num_q[NUM_BITS-1]};
	assign diff  = trial - {1'b0, den_q};
	assign busy  = (cnt_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_BITS'(NUM_BITS);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= numer;
			den_q <= denom;
			rem_q <= '0;
			quot  <= '0;
		end else if (busy) begin
			num_q <= num_q << 1;
			if (!diff[DEN_BITS]) begin
				rem_q <= diff;
				quot  <= {quot[NUM_BITS-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quot  <= {quot[NUM_BITS-2:0], 1'b0};
			end
		end
	end
endmodule
`default_nettype wire

// File: rtl/lscn_lane.sv
// One sensor lane: min/max tracking, level normalization with its own divider.
// Depends on lscn_pkg and lscn_divider.
`timescale 1ns / 1ps
`default_nettype none
module lscn_lane
	import lscn_pkg::*;
#(
	parameter int RAW_BITS = 16
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  lane_cmd_t             cmd,
	input  wire [RAW_BITS-1:0]    raw,
	output logic                  busy,
	output logic [LEVEL_BITS-1:0] level
);
	localparam int NUM_BITS = RAW_BITS + 10;

	logic [RAW_BITS-1:0]   min_q, max_q;
	logic [LEVEL_BITS-1:0] level_q;
	logic                  pend_q;
	logic                  div_start;
	logic [NUM_BITS-1:0]   numer, quot;
	logic [RAW_BITS-1:0]   span;
	logic                  div_busy;
	logic                  skip;

	// raw at or below min or inverted/zero span clamps to 0 without dividing
	assign span  = max_q - min_q;
	assign skip  = (max_q <= min_q) || (raw <= min_q);
	assign numer = NUM_BITS'(raw - min_q) * NUM_BITS'(LEVEL_FULL);
	assign div_start = cmd.norm && !skip;
	assign busy  = div_busy || div_start || pend_q;
	assign level = level_q;

	lscn_divider #(.NUM_BITS(NUM_BITS), .DEN_BITS(RAW_BITS)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.numer(numer), .denom(span), .busy(div_busy), .quot(quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q   <= '1;
			max_q   <= '0;
			level_q <= '0;
			pend_q  <= 1'b0;
		end else begin
			if (cmd.clear) begin
				min_q   <= '1;
				max_q   <= '0;
				level_q <= '0;
			end
			if (cmd.track) begin
				if (raw < min_q) min_q <= raw;
				if (raw > max_q) max_q <= raw;
			end
			if (cmd.norm && skip) begin
				level_q <= '0;
			end
			if (div_start) begin
				pend_q <= 1'b1;
			end else if (pend_q && !div_busy) begin
				pend_q  <= 1'b0;
				level_q <= (quot > NUM_BITS'(LEVEL_FULL)) ? LEVEL_FULL
					: quot[LEVEL_BITS-1:0];
			end
		end
	end
endmodule
`default_nettype wire

// File: rtl/lscn_merge.sv
// Merging stage: compares every lane level against the two thresholds.
// Depends on lscn_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lscn_merge
	import lscn_pkg::*;
(
	input  wire [NUM_SENSORS-1:0][LEVEL_BITS-1:0] levels,
	input  wire [THR_BITS-1:0]                    white_thr,
	input  wire [THR_BITS-1:0]                    flip_thr,
	output logic                                  white_seen,
	output logic                                  flipped
);
	always_comb begin
		white_seen = 1'b0;
		flipped    = 1'b1;
		for (int i = 0; i < NUM_SENSORS; i++) begin
			if (levels[i] < white_thr) white_seen = 1'b1;
			if (levels[i] < flip_thr)  flipped    = 1'b0;
		end
	end
endmodule
`default_nettype wire

// File: rtl/line_sensor_calibrate_normalize_core.sv
// Line sensor calibrate/normalize core: six lanes in parallel, each with its own divider.
// Outside ready mode a request passes the work and hold states into the output register; in ready
// mode the hold state also waits for the bit-serial divider in each lane. One request at a time:
// a new request is taken only when the control is idle and the previous result has been taken.
// Reset (asynchronous, active low): mode not_calibrated, min all ones, max and levels 0,
// thresholds 1 and 992.
`timescale 1ns / 1ps
`default_nettype none
module line_sensor_calibrate_normalize_core
	import lscn_pkg::*;
#(
	parameter int RAW_BITS = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_we,
	input  wire [0:0]   cfg_index,
	input  wire [9:0]   cfg_data,
	input  wire         in_valid,
	output logic        in_stall,
	input  wire [15:0]  raw_time_0,
	input  wire [15:0]  raw_time_1,
	input  wire [15:0]  raw_time_2,
	input  wire [15:0]  raw_time_3,
	input  wire [15:0]  raw_time_4,
	input  wire [15:0]  raw_time_5,
	input  wire         toggle_calibration,
	output logic        out_valid,
	input  wire         out_stall,
	output logic [9:0]  level_0,
	output logic [9:0]  level_1,
	output logic [9:0]  level_2,
	output logic [9:0]  level_3,
	output logic [9:0]  level_4,
	output logic [9:0]  level_5,
	output logic [2:0]  mode,
	output logic        white_seen,
	output logic        flipped
);
	ctl_state_t state_q, state_d;
	mode_t      mode_q, mode_d;
	logic [THR_BITS-1:0] white_thr_q, flip_thr_q;
	logic        accept;
	lane_cmd_t   cmd;
	logic [NUM_SENSORS-1:0] lane_busy;
	logic [NUM_SENSORS-1:0][LEVEL_BITS-1:0] levels;
	logic [NUM_SENSORS-1:0][15:0] raw_all;
	logic [NUM_SENSORS-1:0][RAW_BITS-1:0] raw_s1;
	logic [NUM_SENSORS-1:0][LEVEL_BITS-1:0] lvl_out_q;
	logic        white_d, flip_d, white_q, flip_q;
	logic        out_valid_q;
	logic        load_out;

	assign raw_all = {raw_time_5, raw_time_4, raw_time_3, raw_time_2, raw_time_1, raw_time_0};

	// take the request only when idle and the output register is free
	assign in_stall = (state_q != CTL_IDLE) || out_valid_q;
	assign accept   = in_valid && !in_stall;

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			white_thr_q <= WHITE_THR_RESET;
			flip_thr_q  <= FLIP_THR_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_WHITE_THR: white_thr_q <= cfg_data;
				CFG_FLIP_THR:  flip_thr_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// capture the raw times for the lanes; lanes read them during the work state
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < NUM_SENSORS; i++) begin
				raw_s1[i] <= raw_all[i][RAW_BITS-1:0];
			end
		end
	end

	logic toggle_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= CTL_IDLE;
			mode_q   <= MODE_NOT_CAL;
			toggle_q <= 1'b0;
		end else begin
			state_q <= state_d;
			mode_q  <= mode_d;
			if (accept) toggle_q <= toggle_calibration;
		end
	end

	// WORK: issue the lane command for the current mode and pick the next mode.
	// HOLD: wait for the lane dividers, then load the output register.
	always_comb begin
		state_d  = state_q;
		mode_d   = mode_q;
		cmd      = '0;
		load_out = 1'b0;
		case (state_q)
			CTL_IDLE: begin
				if (accept) state_d = CTL_WORK;
			end
			CTL_WORK: begin
				state_d = CTL_HOLD;
				case (mode_q)
					MODE_START: begin
						cmd.clear = 1'b1;
						mode_d = MODE_CALIB;
					end
					MODE_CALIB: begin
						cmd.track = 1'b1;
						if (toggle_q) mode_d = MODE_STOP;
					end
					MODE_STOP: mode_d = MODE_READY;
					MODE_READY: begin
						cmd.norm = 1'b1;
						if (toggle_q) mode_d = MODE_START;
					end
					default: mode_d = toggle_q ? MODE_START : MODE_NOT_CAL;
				endcase
			end
			CTL_HOLD: begin
				if (lane_busy == '0) begin
					load_out = 1'b1;
					state_d  = CTL_IDLE;
				end
			end
			default: state_d = CTL_IDLE;
		endcase
	end

	for (genvar g = 0; g < NUM_SENSORS; g++) begin : g_lane
		lscn_lane #(.RAW_BITS(RAW_BITS)) u_lane (
			.clk(clk), .arst_n(arst_n), .cmd(cmd), .raw(raw_s1[g]),
			.busy(lane_busy[g]), .level(levels[g])
		);
	end

	lscn_merge u_merge (
		.levels(levels), .white_thr(white_thr_q), .flip_thr(flip_thr_q),
		.white_seen(white_d), .flipped(flip_d)
	);

	// output register: hold until taken downstream
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			lvl_out_q <= levels;
			white_q   <= white_d;
			flip_q    <= flip_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign level_0    = lvl_out_q[0];
	assign level_1    = lvl_out_q[1];
	assign level_2    = lvl_out_q[2];
	assign level_3    = lvl_out_q[3];
	assign level_4    = lvl_out_q[4];
	assign level_5    = lvl_out_q[5];
	assign mode       = mode_q;
	assign white_seen = white_q;
	assign flipped    = flip_q;

	// no request is taken while a result waits
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !accept) else $error("request taken while result pending");
	// a load leaves the control idle with a result waiting
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> state_q == CTL_IDLE && out_valid_q) else $error("bad load");
	// the mode only moves in the work state
	a_mode_stable: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != CTL_WORK |=> $stable(mode_q)) else $error("mode moved outside work");
endmodule
`default_nettype wire
